/* rtl/core/deq_pkg.sv */
// ============================================================================
// deq_pkg - Shared types for the double-ended queue
// Operation and status codes, transaction payloads and the control word
// that steers one chain of storage cells.
// ============================================================================
package deq_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OCC_W  = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CH_HOLD      = 2'd0,
        CH_SHIFT_IN  = 2'd1,
        CH_SHIFT_OUT = 2'd2,
        CH_WRITE     = 2'd3
    } t_chain_op;

    typedef struct packed {
        t_chain_op          op;
        logic [WORD_W-1:0]  value;
    } t_chain_ctrl;

    typedef struct packed {
        t_op                       operation;
        logic signed [WORD_W-1:0]  push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0]  popped_value;
        t_status                   status;
        logic [OCC_W-1:0]          occupancy;
    } t_out_item;

endpackage

/* rtl/core/deq_stream_if.sv */
// ============================================================================
// deq_stream_if - Valid/ready channel
// Carries one payload per transaction; a transaction completes on a rising
// clock edge with valid and ready both high.
// ============================================================================
interface deq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/deq_cell.sv */
// ============================================================================
// deq_cell - One storage cell of a chain
// Holds one word and loads it from either neighbor or from the push value.
// ============================================================================
module deq_cell (
    input  logic                         i_clk,
    input  deq_pkg::t_chain_ctrl         i_ctrl,
    input  logic                         i_sel,
    input  logic [deq_pkg::WORD_W-1:0]   i_prev,
    input  logic [deq_pkg::WORD_W-1:0]   i_next,
    output logic [deq_pkg::WORD_W-1:0]   o_data
);

    logic [deq_pkg::WORD_W-1:0] r_data;
    logic [deq_pkg::WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            deq_pkg::CH_SHIFT_IN:  n_data = i_prev;
            deq_pkg::CH_SHIFT_OUT: n_data = i_next;
            deq_pkg::CH_WRITE: begin
                if (i_sel) begin
                    n_data = i_ctrl.value;
                end
            end
            default:               n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* rtl/core/deq_chain.sv */
// ============================================================================
// deq_chain - Row of storage cells
// Cell zero holds the entry at the chain's own end of the queue; entries
// shift one cell per transaction, and a write lands in the cell whose place
// equals the current occupancy.
// ============================================================================
module deq_chain #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                         i_clk,
    input  deq_pkg::t_chain_ctrl         i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]   i_count,
    output logic [deq_pkg::WORD_W-1:0]   o_head
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [deq_pkg::WORD_W-1:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [deq_pkg::WORD_W-1:0] w_prev;
        logic [deq_pkg::WORD_W-1:0] w_next;
        logic                       w_sel;

        if (g == 0) begin : g_first
            assign w_prev = i_ctrl.value;
        end else begin : g_mid
            assign w_prev = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_body
            assign w_next = w_data[g+1];
        end

        assign w_sel = (i_count == CNT_W'(g));

        deq_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (i_ctrl),
            .i_sel  (w_sel),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

/* rtl/core/double_ended_queue.sv */
// ============================================================================
// double_ended_queue - Bounded deque of signed 32-bit words
// Each input transaction on i_in carries an operation (push front, push rear,
// pop front, pop rear) and a push value. Each one yields exactly one output
// transaction on o_out with the popped word, a status code and the occupancy
// after the operation. A pop on an empty queue reports underflow and a push
// on a full queue reports overflow; neither changes the contents.
// Words live in two rows of DEPTH cells: one keeps the front entry in its
// first cell, the other keeps the rear entry in its first cell, so both pops
// read a fixed cell and every cell talks only to its neighbors.
// Each result is registered and appears on o_out in the cycle after its input
// transaction, and one transaction is taken per cycle as long as the output
// register is empty or is being drained in the same cycle. When the receiver
// stalls, the result holds and i_in.ready drops until it is taken.
// Reset empties the queue and clears the output valid; cell contents are
// left as they are and are never read before being written.
// ============================================================================
module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_stream_if.sink   i_in,
    deq_stream_if.source o_out
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_out_valid;
    logic                         n_out_valid;
    deq_pkg::t_out_item           r_out_data;
    deq_pkg::t_out_item           n_out_data;
    deq_pkg::t_chain_ctrl         w_front_ctrl;
    deq_pkg::t_chain_ctrl         w_rear_ctrl;
    logic [deq_pkg::WORD_W-1:0]   w_front_head;
    logic [deq_pkg::WORD_W-1:0]   w_rear_head;
    logic                         w_accept;
    logic                         w_empty;
    logic                         w_full;
    deq_pkg::t_in_item            w_item;

    assign w_item   = i_in.data;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_count            = r_count;
        w_front_ctrl.op    = deq_pkg::CH_HOLD;
        w_front_ctrl.value = w_item.push_value;
        w_rear_ctrl.op     = deq_pkg::CH_HOLD;
        w_rear_ctrl.value  = w_item.push_value;
        n_out_data.popped_value = '0;
        n_out_data.status       = deq_pkg::ST_OK;
        if (w_accept) begin
            case (w_item.operation)
                deq_pkg::OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_out_data.status = deq_pkg::ST_OVERFLOW;
                    end else begin
                        w_front_ctrl.op = deq_pkg::CH_SHIFT_IN;
                        w_rear_ctrl.op  = deq_pkg::CH_WRITE;
                        n_count         = r_count + 1'b1;
                    end
                end
                deq_pkg::OP_PUSH_REAR: begin
                    if (w_full) begin
                        n_out_data.status = deq_pkg::ST_OVERFLOW;
                    end else begin
                        w_front_ctrl.op = deq_pkg::CH_WRITE;
                        w_rear_ctrl.op  = deq_pkg::CH_SHIFT_IN;
                        n_count         = r_count + 1'b1;
                    end
                end
                deq_pkg::OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_out_data.status = deq_pkg::ST_UNDERFLOW;
                    end else begin
                        w_front_ctrl.op         = deq_pkg::CH_SHIFT_OUT;
                        n_out_data.popped_value = w_front_head;
                        n_count                 = r_count - 1'b1;
                    end
                end
                default: begin
                    if (w_empty) begin
                        n_out_data.status = deq_pkg::ST_UNDERFLOW;
                    end else begin
                        w_rear_ctrl.op          = deq_pkg::CH_SHIFT_OUT;
                        n_out_data.popped_value = w_rear_head;
                        n_count                 = r_count - 1'b1;
                    end
                end
            endcase
        end
        n_out_data.occupancy = deq_pkg::OCC_W'(n_count);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    deq_chain #(
        .DEPTH (DEPTH)
    ) u_front_chain (
        .i_clk   (i_clk),
        .i_ctrl  (w_front_ctrl),
        .i_count (r_count),
        .o_head  (w_front_head)
    );

    deq_chain #(
        .DEPTH (DEPTH)
    ) u_rear_chain (
        .i_clk   (i_clk),
        .i_ctrl  (w_rear_ctrl),
        .i_count (r_count),
        .o_head  (w_rear_head)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule
